// ===== hdl/qlu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlu_pkg
// Shared types and character codes for the quoted list unescaper.
// ----------------------------------------------------------------------------
package qlu_pkg;

    // parser modes
    typedef enum logic [2:0] {
        MODE_START  = 3'd0,
        MODE_PLAIN  = 3'd1,
        MODE_QUOTED = 3'd2,
        MODE_ESCAPE = 3'd3,
        MODE_AFTER  = 3'd4,
        MODE_ERROR  = 3'd5
    } qlu_mode_t;

    // result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_OK   = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam int MAX_RES = 3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       run_end;
    } qlu_res_t;

endpackage

// ===== hdl/quoted_list_unescaper.sv =====
`timescale 1ns / 1ps
// The first result beat of a byte is registered and shows on m_* in the cycle after the byte is taken.
// Throughput: one byte per cycle while m_ready is high and each byte yields at most one
//   beat; a byte that yields two or three beats holds s_ready low until its beats drain
//   through the single result port (one beat per cycle while m_ready is high).
// Reset: aresetn is sampled synchronously; low returns the parser to word start and drops
//   any pending result beats.
// ----------------------------------------------------------------------------
// quoted_list_unescaper
// Streaming unescaper for a semicolon-separated list of plain or quoted words.
// ----------------------------------------------------------------------------
module quoted_list_unescaper
    import qlu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_final_byte,
    input  logic       s_empty_list,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_kind,
    output logic       m_run_end
);

    // parser mode, updated on every accepted byte
    qlu_mode_t  mode_reg, mode_next;
    qlu_mode_t  dec_mode;
    logic [1:0] dec_cnt;
    qlu_res_t   dec_res [MAX_RES];

    // result buffer: entry 0 drives the port, later entries shift down on pop
    qlu_res_t   buf_reg  [MAX_RES];
    qlu_res_t   buf_next [MAX_RES];
    logic [1:0] cnt_reg, cnt_next;

    logic s_fire, m_fire;

    qlu_decode u_decode (
        .mode       (mode_reg),
        .data_byte  (s_data_byte),
        .final_byte (s_final_byte),
        .empty_list (s_empty_list),
        .mode_next  (dec_mode),
        .res_cnt    (dec_cnt),
        .res        (dec_res)
    );

    // room for a new byte when the buffer is empty or its last beat leaves now
    assign s_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = (cnt_reg != 2'd0);
    assign m_fire  = m_valid && m_ready;

    assign m_out_byte = buf_reg[0].out_byte;
    assign m_kind     = buf_reg[0].kind;
    assign m_run_end  = buf_reg[0].run_end;

    always_comb begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        buf_next  = buf_reg;
        if (s_fire) begin
            // new beats replace whatever drains this cycle
            mode_next = dec_mode;
            cnt_next  = dec_cnt;
            buf_next  = dec_res;
        end else if (m_fire) begin
            cnt_next    = cnt_reg - 2'd1;
            buf_next[0] = buf_reg[1];
            buf_next[1] = buf_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_START;
            cnt_reg  <= 2'd0;
        end else begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

endmodule

// ===== hdl/qlu_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlu_decode
// Per-byte parser step: next mode and up to three result beats.
// ----------------------------------------------------------------------------
module qlu_decode
    import qlu_pkg::*;
(
    input  qlu_mode_t  mode,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    input  logic       empty_list,
    output qlu_mode_t  mode_next,
    output logic [1:0] res_cnt,
    output qlu_res_t   res [MAX_RES]
);

    logic [1:0] k0, k1, k2;
    logic [7:0] b0;
    logic [1:0] cnt;
    logic       blank;
    logic [7:0] esc_byte;

    assign blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB);

    always_comb begin
        if (data_byte == CH_R) begin
            esc_byte = CH_CR;
        end else if (data_byte == CH_N) begin
            esc_byte = CH_LF;
        end else begin
            esc_byte = data_byte;
        end
    end

    always_comb begin
        k0        = KIND_BYTE;
        k1        = KIND_BYTE;
        k2        = KIND_BYTE;
        b0        = data_byte;
        cnt       = 2'd0;
        mode_next = mode;

        if (empty_list) begin
            k0        = KIND_OK;
            cnt       = 2'd1;
            mode_next = MODE_START;
        end else begin
            unique case (mode)
                MODE_START, MODE_PLAIN: begin
                    if (mode == MODE_START && blank) begin
                        if (final_byte) begin
                            k0  = KIND_OK;
                            cnt = 2'd1;
                        end
                    end else if (mode == MODE_START && data_byte == CH_QUOTE) begin
                        if (final_byte) begin
                            k0        = KIND_ERR;
                            cnt       = 2'd1;
                        end else begin
                            mode_next = MODE_QUOTED;
                        end
                    end else if (data_byte == CH_SEMI) begin
                        k0 = KIND_END;
                        if (final_byte) begin
                            k1  = KIND_END;
                            k2  = KIND_OK;
                            cnt = 2'd3;
                        end else begin
                            cnt       = 2'd1;
                            mode_next = MODE_START;
                        end
                    end else begin
                        k0        = KIND_BYTE;
                        mode_next = MODE_PLAIN;
                        if (final_byte) begin
                            k1  = KIND_END;
                            k2  = KIND_OK;
                            cnt = 2'd3;
                        end else begin
                            cnt = 2'd1;
                        end
                    end
                end
                MODE_QUOTED: begin
                    if (data_byte == CH_QUOTE) begin
                        k0 = KIND_END;
                        if (final_byte) begin
                            k1  = KIND_OK;
                            cnt = 2'd2;
                        end else begin
                            cnt       = 2'd1;
                            mode_next = MODE_AFTER;
                        end
                    end else if (data_byte == CH_BSL) begin
                        if (final_byte) begin
                            k0  = KIND_ERR;
                            cnt = 2'd1;
                        end else begin
                            mode_next = MODE_ESCAPE;
                        end
                    end else begin
                        k0 = KIND_BYTE;
                        if (final_byte) begin
                            k1  = KIND_ERR;
                            cnt = 2'd2;
                        end else begin
                            cnt = 2'd1;
                        end
                    end
                end
                MODE_ESCAPE: begin
                    k0 = KIND_BYTE;
                    b0 = esc_byte;
                    if (final_byte) begin
                        k1  = KIND_ERR;
                        cnt = 2'd2;
                    end else begin
                        cnt       = 2'd1;
                        mode_next = MODE_QUOTED;
                    end
                end
                MODE_AFTER: begin
                    if (blank) begin
                        if (final_byte) begin
                            k0  = KIND_OK;
                            cnt = 2'd1;
                        end
                    end else if (data_byte == CH_SEMI) begin
                        if (final_byte) begin
                            k0  = KIND_END;
                            k1  = KIND_OK;
                            cnt = 2'd2;
                        end else begin
                            mode_next = MODE_START;
                        end
                    end else begin
                        k0        = KIND_ERR;
                        cnt       = 2'd1;
                        mode_next = MODE_ERROR;
                    end
                end
                MODE_ERROR: begin
                    cnt = 2'd0;
                end
                default: begin
                    cnt = 2'd0;
                end
            endcase

            // any error parks the parser until the last byte
            if ((cnt == 2'd1 && k0 == KIND_ERR) || (cnt == 2'd2 && k1 == KIND_ERR)) begin
                mode_next = MODE_ERROR;
            end
            if (final_byte) begin
                mode_next = MODE_START;
            end
        end
    end

    assign res_cnt = cnt;

    always_comb begin
        res[0].out_byte = (k0 == KIND_BYTE) ? b0 : 8'h00;
        res[0].kind     = k0;
        res[0].run_end  = (cnt == 2'd1);
        res[1].out_byte = 8'h00;
        res[1].kind     = k1;
        res[1].run_end  = (cnt == 2'd2);
        res[2].out_byte = 8'h00;
        res[2].kind     = k2;
        res[2].run_end  = (cnt == 2'd3);
    end

endmodule
